>>> rtl/core/signed_int_to_decimal_ascii_assert.svh
// Assertion macros for the signed integer to decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

`ifndef ASSERT_OFF
`define SITDA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");
`define SITDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");
`else
`define SITDA_ASSERT_SAME(label, ante, cons)
`define SITDA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/core/sitda_pkg.sv
// Types and constants shared by the decimal text converter.
`default_nettype none

package sitda_pkg;

    localparam int C_VALUE_W    = 32;
    localparam int C_CHAR_W     = 8;
    localparam int C_DIGIT_W    = 4;
    localparam int C_NUM_DIGITS = 10;
    localparam int C_BCD_W      = C_NUM_DIGITS * C_DIGIT_W;

    typedef logic signed [C_VALUE_W-1:0] t_value;
    typedef logic [C_VALUE_W-1:0]        t_mag;
    typedef logic [C_CHAR_W-1:0]         t_char;
    typedef logic [C_DIGIT_W-1:0]        t_digit;
    typedef logic [C_BCD_W-1:0]          t_bcd;

    localparam t_char C_ASCII_ZERO  = 8'h30;
    localparam t_char C_ASCII_MINUS = 8'h2D;

    localparam t_digit C_ADJ_LIMIT = 4'd5;
    localparam t_digit C_ADJ_ADD   = 4'd3;

endpackage

`default_nettype wire

>>> rtl/core/sitda_if.sv
// Valid/ready channels for input values and output characters.
`default_nettype none

interface sitda_value_if;
    logic              valid;
    logic              ready;
    sitda_pkg::t_value value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sitda_char_if;
    logic             valid;
    logic             ready;
    sitda_pkg::t_char character;
    logic             last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text, one character per word.
//
//  channel   dir  payload           notes
//  i_value   in   value[31:0] s     one word per number
//  o_char    out  character[7:0]    '-' if negative, then digits, last on final digit
//                 last
//
// One number at a time. The value is accepted, shifted through the binary to
// BCD conversion bit by bit and its leading zero digits are skipped; then the sign
// (when negative) and the digits go out one per cycle while o_char is not stalled.
// Output stalls hold the current character. Reset clears the state only.
`default_nettype none
`include "signed_int_to_decimal_ascii_assert.svh"

module signed_int_to_decimal_ascii (
    input  wire             i_clk,
    input  wire             i_rst_n,
    sitda_value_if.sink     i_value,
    sitda_char_if.source    o_char
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam int BIT_CNT_W = $clog2(sitda_pkg::C_VALUE_W);
    localparam int LEFT_W    = $clog2(sitda_pkg::C_NUM_DIGITS + 1);

    logic [2:0]            r_state, n_state;
    logic [BIT_CNT_W-1:0]  r_bit, n_bit;
    logic [LEFT_W-1:0]     r_left, n_left;
    logic                  r_neg, n_neg;
    sitda_pkg::t_mag       r_mag, n_mag;
    sitda_pkg::t_bcd       r_bcd, n_bcd;

    sitda_pkg::t_bcd       w_adj;
    sitda_pkg::t_digit     w_top;
    logic                  w_in_acc;
    logic                  w_out_acc;
    logic                  w_is_last;

    assign w_top     = r_bcd[sitda_pkg::C_BCD_W-1 -: sitda_pkg::C_DIGIT_W];
    assign w_in_acc  = i_value.valid && i_value.ready;
    assign w_out_acc = o_char.valid && o_char.ready;
    assign w_is_last = (r_state == ST_EMIT) && (r_left == LEFT_W'(1));

    assign i_value.ready = (r_state == ST_IDLE);
    assign o_char.valid  = (r_state == ST_SIGN) || (r_state == ST_EMIT);
    assign o_char.last   = w_is_last;
    assign o_char.character = (r_state == ST_SIGN) ? sitda_pkg::C_ASCII_MINUS
        : sitda_pkg::t_char'(sitda_pkg::C_ASCII_ZERO + {4'd0, w_top});

    // add-3 on every BCD digit of five or more
    always_comb begin
        sitda_pkg::t_digit d;
        for (int i = 0; i < sitda_pkg::C_NUM_DIGITS; i++) begin
            d = r_bcd[i*sitda_pkg::C_DIGIT_W +: sitda_pkg::C_DIGIT_W];
            w_adj[i*sitda_pkg::C_DIGIT_W +: sitda_pkg::C_DIGIT_W] =
                (d >= sitda_pkg::C_ADJ_LIMIT) ? sitda_pkg::t_digit'(d + sitda_pkg::C_ADJ_ADD)
                                              : d;
        end
    end

    always_comb begin
        n_state = r_state;
        n_bit   = r_bit;
        n_left  = r_left;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_bcd   = r_bcd;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_neg   = i_value.value[sitda_pkg::C_VALUE_W-1];
                    n_mag   = n_neg ? sitda_pkg::t_mag'(32'd0 - $unsigned(i_value.value))
                                    : $unsigned(i_value.value);
                    n_bcd   = '0;
                    n_bit   = '0;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd = {w_adj[sitda_pkg::C_BCD_W-2:0], r_mag[sitda_pkg::C_VALUE_W-1]};
                n_mag = {r_mag[sitda_pkg::C_VALUE_W-2:0], 1'b0};
                n_bit = BIT_CNT_W'(r_bit + 1'b1);
                if (r_bit == BIT_CNT_W'(sitda_pkg::C_VALUE_W - 1)) begin
                    n_left  = LEFT_W'(sitda_pkg::C_NUM_DIGITS);
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if ((w_top == '0) && (r_left != LEFT_W'(1))) begin
                    n_bcd  = {r_bcd[sitda_pkg::C_BCD_W-sitda_pkg::C_DIGIT_W-1:0],
                              sitda_pkg::C_DIGIT_W'(0)};
                    n_left = LEFT_W'(r_left - 1'b1);
                end else begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (w_out_acc) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_acc) begin
                    n_bcd  = {r_bcd[sitda_pkg::C_BCD_W-sitda_pkg::C_DIGIT_W-1:0],
                              sitda_pkg::C_DIGIT_W'(0)};
                    n_left = LEFT_W'(r_left - 1'b1);
                    if (w_is_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bit  <= n_bit;
        r_left <= n_left;
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
    end

    `SITDA_ASSERT_SAME(a_one_side, 1'b1, !(i_value.ready && o_char.valid))
    `SITDA_ASSERT_NEXT(a_idle_after_last, w_out_acc && o_char.last, i_value.ready)
    `SITDA_ASSERT_SAME(a_left_range, o_char.valid,
        (r_left != '0) && (r_left <= LEFT_W'(sitda_pkg::C_NUM_DIGITS)))
    `SITDA_ASSERT_SAME(a_minus_not_last,
        o_char.valid && (o_char.character == sitda_pkg::C_ASCII_MINUS), !o_char.last)

endmodule

`default_nettype wire
